FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the STA/LTA detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("STA/LTA detector assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("STA/LTA detector assertion failed");

`endif

FILE: hw/rtl/stalta_pkg.sv
// Package with the constants and register codes of the STA/LTA detector.
`timescale 1ns / 1ps

package stalta_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int LEN_W   = 12;
    localparam int AGE_W   = LEN_W + 1;
    localparam int RATIO_W = 32;
    localparam int FRAC_W  = 16;
    localparam int QCNT_W  = $clog2(RATIO_W);

    localparam logic [0:0] REG_STA = 1'b0;
    localparam logic [0:0] REG_LTA = 1'b1;

    localparam logic [LEN_W-1:0] STA_RESET = 12'd16;
    localparam logic [LEN_W-1:0] LTA_RESET = 12'd256;

    localparam logic [RATIO_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 32'hFFFF_FFFF;

endpackage

FILE: hw/rtl/stalta_if.sv
// Request channel interfaces for the sample input and the ratio output.
`timescale 1ns / 1ps

interface stalta_in_if
    import stalta_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface stalta_out_if
    import stalta_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RATIO_W-1:0] ratio;
    logic               warmed;
    logic               config_bad;

    modport source (output valid, output ratio, output warmed, output config_bad, input ready);
    modport sink   (input valid, input ratio, input warmed, input config_bad, output ready);
endinterface

FILE: hw/rtl/sta_lta_ratio_detector.sv
// STA/LTA trigger ratio detector: delay store, running sums and Q16.16 ratio divider.
//
// Each accepted sample request yields one result request carrying the ratio
// (short_sum*lta_length)/(long_sum*sta_length) in unsigned Q16.16, saturated.
// A computed ratio goes through three reads of the delay store via its single
// read port, the last of which also updates the sums, a warm-up check, the two
// multiplies, a range check, the restoring divider and a handoff. A warm-up
// result leaves after its check, a zero long sum after the multiplies, a
// saturated ratio after the range check, and a sample taken while the windows
// exceed the store goes straight to the handoff. The input is not ready while
// an item is in work, but a new sample is taken while the last result still
// waits in the output register. There is no clearing pass: a fill count makes
// entries unwritten since reset or the last nonzero length write read as zero.
// Length writes must be made only while idle; the block does not enforce it.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sta_lta_ratio_detector
    import stalta_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    stalta_in_if.sink         samples,
    stalta_out_if.source      results
);

    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int FW     = AW + 1;
    localparam int CW     = ((FW > AGE_W) ? FW : AGE_W) + 1;
    localparam int SUM_W  = SAMPLE_BITS + AW;
    localparam int PW     = SUM_W + LEN_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD_S  = 4'd1;
    localparam logic [3:0] ST_RD_S1 = 4'd2;
    localparam logic [3:0] ST_RD_SL = 4'd3;
    localparam logic [3:0] ST_GET   = 4'd4;
    localparam logic [3:0] ST_UPD   = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_CHK   = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    function automatic logic [SAMPLE_BITS-1:0] mag_f(input logic [SAMPLE_BITS-1:0] x);
        return x[SAMPLE_BITS-1] ? (~x + SAMPLE_BITS'(1)) : x;
    endfunction

    logic [3:0]             state_reg;
    logic [LEN_W-1:0]       sta_reg;
    logic [LEN_W-1:0]       lta_reg;
    logic [AW-1:0]          wp_reg;
    logic [FW-1:0]          fill_reg;
    logic [SUM_W-1:0]       short_reg;
    logic [SUM_W-1:0]       long_reg;
    logic [AGE_W-1:0]       warm_cnt_reg;
    logic                   enabled_reg;

    logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_ok_reg;

    logic [SAMPLE_BITS-1:0] mag0_reg;
    logic [SAMPLE_BITS-1:0] mag_s_reg;
    logic [SAMPLE_BITS-1:0] mag_s1_reg;
    logic [PW-1:0]          num_reg;
    logic [PW-1:0]          den_reg;
    logic [PW-1:0]          rem_reg;
    logic [RATIO_W-1:0]     dvd_reg;
    logic [RATIO_W-1:0]     quo_reg;
    logic [QCNT_W-1:0]      qcnt_reg;

    logic [RATIO_W-1:0]     res_ratio_reg;
    logic                   res_warmed_reg;
    logic                   res_bad_reg;

    logic                   out_valid_reg;
    logic [RATIO_W-1:0]     out_ratio_reg;
    logic                   out_warmed_reg;
    logic                   out_bad_reg;

    logic [AGE_W-1:0]       len_sum;
    logic                   cfg_bad;
    logic                   accept;
    logic [AW-1:0]          wp_next;
    logic [AGE_W-1:0]       age_sel;
    logic [CW-1:0]          idx_wide;
    logic [AW-1:0]          rd_addr;
    logic                   rd_ok;
    logic [SAMPLE_BITS-1:0] rd_mag;
    logic [PW:0]            div_shift;
    logic [PW:0]            div_diff;
    logic                   div_bit;
    logic                   out_free;

    assign len_sum  = AGE_W'(sta_reg) + AGE_W'(lta_reg);
    assign cfg_bad  = CW'(len_sum) > CW'(WINDOW_DEPTH);
    assign accept   = samples.valid && samples.ready;
    assign wp_next  = (CW'(wp_reg) == CW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign rd_mag   = rd_ok_reg ? mag_f(rd_data_reg) : '0;
    assign out_free = !out_valid_reg || results.ready;

    assign samples.ready      = (state_reg == ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.ratio      = out_ratio_reg;
    assign results.warmed     = out_warmed_reg;
    assign results.config_bad = out_bad_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_RD_S:  age_sel = AGE_W'(sta_reg);
            ST_RD_S1: age_sel = AGE_W'(sta_reg) - AGE_W'(1);
            ST_RD_SL: age_sel = len_sum - AGE_W'(1);
            default:  age_sel = '0;
        endcase
    end

    always_comb
    begin
        idx_wide = CW'(wp_reg) + CW'(WINDOW_DEPTH) - CW'(age_sel);
        if (idx_wide >= CW'(WINDOW_DEPTH))
        begin
            idx_wide = idx_wide - CW'(WINDOW_DEPTH);
        end
        rd_addr = idx_wide[AW-1:0];
        rd_ok   = CW'(age_sel) < CW'(fill_reg);
    end

    assign div_shift = {rem_reg, dvd_reg[RATIO_W-1]};
    assign div_diff  = div_shift - {1'b0, den_reg};
    assign div_bit   = !div_diff[PW];

    always_ff @(posedge clk)
    begin
        if (accept && !cfg_bad)
        begin
            mem[wp_next] <= SAMPLE_BITS'(samples.sample);
        end
        rd_data_reg <= mem[rd_addr];
        rd_ok_reg   <= rd_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sta_reg       <= STA_RESET;
            lta_reg       <= LTA_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            short_reg     <= '0;
            long_reg      <= '0;
            warm_cnt_reg  <= '0;
            enabled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && results.ready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we && (cfg_data != '0))
            begin
                unique case (cfg_index)
                    REG_STA: sta_reg <= cfg_data;
                    REG_LTA: lta_reg <= cfg_data;
                    default: ;
                endcase
                wp_reg       <= '0;
                fill_reg     <= '0;
                short_reg    <= '0;
                long_reg     <= '0;
                warm_cnt_reg <= '0;
                enabled_reg  <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cfg_bad)
                        begin
                            res_ratio_reg  <= Q_ONE;
                            res_warmed_reg <= 1'b0;
                            res_bad_reg    <= 1'b1;
                            state_reg      <= ST_FIN;
                        end
                        else
                        begin
                            wp_reg   <= wp_next;
                            mag0_reg <= mag_f(SAMPLE_BITS'(samples.sample));
                            if (fill_reg != FW'(WINDOW_DEPTH))
                            begin
                                fill_reg <= fill_reg + FW'(1);
                            end
                            state_reg <= ST_RD_S;
                        end
                    end
                end
                ST_RD_S:
                begin
                    state_reg <= ST_RD_S1;
                end
                ST_RD_S1:
                begin
                    mag_s_reg <= rd_mag;
                    state_reg <= ST_RD_SL;
                end
                ST_RD_SL:
                begin
                    mag_s1_reg <= rd_mag;
                    state_reg  <= ST_GET;
                end
                ST_GET:
                begin
                    short_reg <= short_reg + SUM_W'(mag0_reg) - SUM_W'(mag_s_reg);
                    long_reg  <= long_reg + SUM_W'(mag_s1_reg) - SUM_W'(rd_mag);
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    res_ratio_reg <= Q_ONE;
                    res_bad_reg   <= 1'b0;
                    if (enabled_reg)
                    begin
                        res_warmed_reg <= 1'b1;
                        state_reg      <= ST_MUL;
                    end
                    else
                    begin
                        res_warmed_reg <= 1'b0;
                        if (warm_cnt_reg < len_sum - AGE_W'(1))
                        begin
                            warm_cnt_reg <= warm_cnt_reg + AGE_W'(1);
                        end
                        else
                        begin
                            enabled_reg <= 1'b1;
                        end
                        state_reg <= ST_FIN;
                    end
                end
                ST_MUL:
                begin
                    num_reg <= PW'(short_reg) * PW'(lta_reg);
                    den_reg <= PW'(long_reg) * PW'(sta_reg);
                    if (long_reg == '0)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    if ((PW + FRAC_W)'(num_reg) >= {den_reg, FRAC_W'(0)})
                    begin
                        res_ratio_reg <= RATIO_MAX;
                        state_reg     <= ST_FIN;
                    end
                    else
                    begin
                        rem_reg   <= num_reg >> FRAC_W;
                        dvd_reg   <= {num_reg[FRAC_W-1:0], FRAC_W'(0)};
                        quo_reg   <= '0;
                        qcnt_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= div_bit ? div_diff[PW-1:0] : div_shift[PW-1:0];
                    dvd_reg  <= {dvd_reg[RATIO_W-2:0], 1'b0};
                    quo_reg  <= {quo_reg[RATIO_W-2:0], div_bit};
                    qcnt_reg <= qcnt_reg + QCNT_W'(1);
                    if (qcnt_reg == QCNT_W'(RATIO_W - 1))
                    begin
                        res_ratio_reg <= {quo_reg[RATIO_W-2:0], div_bit};
                        state_reg     <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_ratio_reg  <= res_ratio_reg;
                        out_warmed_reg <= res_warmed_reg;
                        out_bad_reg    <= res_bad_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NXT(a_accept_busy, accept, state_reg != ST_IDLE)
    `ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FW'(WINDOW_DEPTH))
    `ASSERT_IMP(a_rem_below_den, state_reg == ST_DIV, rem_reg < den_reg)
    `ASSERT_IMP(a_warm_excl_bad, out_valid_reg, !(out_warmed_reg && out_bad_reg))

endmodule

FILE: test/testbench.sv
// Self-checking testbench of the STA/LTA ratio detector with its own ratio predictor.
`timescale 1ns / 1ps

module testbench;
    import stalta_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    localparam int SBITS = SAMPLE_BITS_DEF;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_ITEMS = 250;
    localparam int FULL_STORE_ITEMS = 150;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               warmed;
        logic               config_bad;
    } ratio_result_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [0:0]       cfg_index;
    logic [LEN_W-1:0] cfg_data;

    stalta_in_if #(.SAMPLE_BITS(SBITS)) sample_ch ();
    stalta_out_if result_ch ();

    sta_lta_ratio_detector #(
        .WINDOW_DEPTH(DEPTH),
        .SAMPLE_BITS(SBITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .samples(sample_ch),
        .results(result_ch)
    );

    logic [SBITS-1:0] line_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [63:0]      short_acc;
    logic [63:0]      long_acc;
    int unsigned      warm_count;
    bit               detector_on;
    int unsigned      sta_len;
    int unsigned      lta_len;

    ratio_result_t expected_ratios [$];

    bit          idle_enabled = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned samples_sent = 0;
    int unsigned random_items = 0;
    int unsigned window_settings = 0;
    int unsigned length_writes = 0;
    int unsigned computed_count = 0;
    int unsigned saturated_count = 0;
    int unsigned zero_long_count = 0;
    int unsigned oversized_count = 0;
    int unsigned quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic logic [63:0] magnitude_of(logic [SBITS-1:0] raw);
        logic [SBITS-1:0] neg;
        neg = ~raw + 1'b1;
        return raw[SBITS-1] ? 64'(neg) : 64'(raw);
    endfunction

    function automatic logic [63:0] aged_magnitude(int unsigned age);
        logic [PTR_W-1:0] idx;
        idx = wr_ptr - PTR_W'(age);
        return magnitude_of(line_mem[idx]);
    endfunction

    function automatic logic [RATIO_W-1:0] q16_quotient(logic [63:0] num, logic [63:0] den);
        logic [63:0]       whole;
        logic [63:0]       rem;
        logic [FRAC_W-1:0] frac;
        whole = num / den;
        rem = num % den;
        frac = '0;
        if (whole > 64'hFFFF)
        begin
            return RATIO_MAX;
        end
        for (int i = 0; i < FRAC_W; i++)
        begin
            rem = rem << 1;
            frac = {frac[FRAC_W-2:0], 1'b0};
            if (rem >= den)
            begin
                rem = rem - den;
                frac[0] = 1'b1;
            end
        end
        return {whole[RATIO_W-FRAC_W-1:0], frac};
    endfunction

    function automatic void clear_windows();
        foreach (line_mem[i])
        begin
            line_mem[i] = '0;
        end
        wr_ptr = '0;
        short_acc = '0;
        long_acc = '0;
        warm_count = 0;
        detector_on = 1'b0;
    endfunction

    function automatic ratio_result_t predict_ratio(logic [SBITS-1:0] value);
        ratio_result_t res;
        res.ratio = Q_ONE;
        res.warmed = 1'b0;
        res.config_bad = 1'b0;
        if (sta_len + lta_len > DEPTH)
        begin
            res.config_bad = 1'b1;
            oversized_count++;
            return res;
        end
        wr_ptr = wr_ptr + 1'b1;
        line_mem[wr_ptr] = value;
        short_acc = short_acc + aged_magnitude(0) - aged_magnitude(sta_len);
        long_acc = long_acc + aged_magnitude(sta_len - 1)
                   - aged_magnitude(sta_len + lta_len - 1);
        if (detector_on)
        begin
            res.warmed = 1'b1;
            if (long_acc != 0)
            begin
                res.ratio = q16_quotient(short_acc * lta_len, long_acc * sta_len);
                computed_count++;
                if (res.ratio == RATIO_MAX)
                begin
                    saturated_count++;
                end
            end
            else
            begin
                zero_long_count++;
            end
        end
        else if (warm_count < sta_len + lta_len - 1)
        begin
            warm_count++;
        end
        else
        begin
            detector_on = 1'b1;
        end
        return res;
    endfunction

    // Amplitudes of SBITS bits or more give a sample drawn over the whole range.
    function automatic logic [SBITS-1:0] noise_sample(int unsigned amp_bits);
        logic [SBITS-1:0] v;
        if (amp_bits >= SBITS)
        begin
            return SBITS'($urandom);
        end
        v = SBITS'($urandom_range(0, (1 << amp_bits) - 1));
        if ($urandom_range(0, 1) == 1)
        begin
            v = -v;
        end
        return v;
    endfunction

    task automatic offer_sample(input logic [SBITS-1:0] value);
        int unsigned gap;
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample <= value;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        expected_ratios.push_back(predict_ratio(value));
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (expected_ratios.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(input logic [0:0] idx, input logic [LEN_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        length_writes++;
        if (val != '0)
        begin
            if (idx == REG_STA)
            begin
                sta_len = val;
            end
            else
            begin
                lta_len = val;
            end
            clear_windows();
        end
    endtask

    task automatic test_reset_lengths();
        window_settings++;
        repeat (STA_RESET + LTA_RESET + 40) offer_sample(noise_sample($urandom_range(0, 23)));
        wait_for_results();
    endtask

    task automatic test_edge_cases();
        write_length(REG_STA, 12'd2);
        write_length(REG_LTA, 12'd4);
        window_settings++;
        repeat (7) offer_sample('0);
        offer_sample(SBITS'(1));
        offer_sample({1'b0, {(SBITS-1){1'b1}}});
        offer_sample({1'b1, {(SBITS-1){1'b0}}});
        offer_sample('1);
        offer_sample(SBITS'(1));
        offer_sample(SBITS'(24'h5A5A5A));
        offer_sample(SBITS'(24'hA5A5A5));
        wait_for_results();
        // A zero length is dropped and the windows carry on.
        write_length(REG_STA, '0);
        repeat (3) offer_sample(noise_sample(12));
        wait_for_results();
        // Writing the same length again still restarts warm-up.
        write_length(REG_LTA, 12'd4);
        repeat (4) offer_sample(noise_sample(20));
        wait_for_results();
    endtask

    task automatic test_oversized_windows();
        write_length(REG_STA, 12'd4095);
        write_length(REG_LTA, 12'd4095);
        window_settings++;
        repeat (5) offer_sample(SBITS'($urandom));
        wait_for_results();
        write_length(REG_STA, 12'd2048);
        write_length(REG_LTA, 12'd2049);
        window_settings++;
        repeat (5) offer_sample(SBITS'($urandom));
        wait_for_results();
    endtask

    task automatic test_full_store_windows();
        write_length(REG_LTA, 12'd1);
        write_length(REG_STA, 12'd4095);
        window_settings++;
        repeat (FULL_STORE_ITEMS) offer_sample(noise_sample($urandom_range(0, 24)));
        wait_for_results();
        write_length(REG_STA, 12'd1);
        write_length(REG_LTA, 12'd4095);
        window_settings++;
        repeat (FULL_STORE_ITEMS) offer_sample(noise_sample($urandom_range(0, 24)));
        wait_for_results();
    endtask

    task automatic test_backpressure();
        write_length(REG_STA, 12'd3);
        write_length(REG_LTA, 12'd10);
        window_settings++;
        repeat (16) offer_sample(noise_sample(16));
        hold_request = 1'b1;
        repeat (30) offer_sample(SBITS'($urandom));
        wait_for_results();
        repeat (20) offer_sample(noise_sample($urandom_range(0, 24)));
        wait_for_results();
    endtask

    task automatic test_random_windows();
        logic [LEN_W-1:0] s;
        logic [LEN_W-1:0] l;
        logic [SBITS-1:0] value;
        int unsigned      span;
        int unsigned      seg_len;
        int unsigned      amp;
        while (random_items < RANDOM_ITEMS)
        begin
            idle_enabled = ($urandom_range(0, 3) != 0) &&
                           (random_items < RANDOM_ITEMS - TAIL_ITEMS);
            case ($urandom_range(0, 9))
                0:
                begin
                    s = 12'd1;
                    l = 12'd1;
                end
                1:
                begin
                    s = LEN_W'($urandom_range(2048, 4095));
                    l = LEN_W'($urandom_range(DEPTH + 1 - s, 4095));
                end
                2:
                begin
                    s = LEN_W'($urandom_range(1, 64));
                    l = LEN_W'($urandom_range(1, 300));
                end
                default:
                begin
                    s = LEN_W'($urandom_range(1, 8));
                    l = LEN_W'($urandom_range(1, 40));
                end
            endcase
            write_length(REG_STA, s);
            write_length(REG_LTA, l);
            if ($urandom_range(0, 7) == 0)
            begin
                write_length(1'($urandom_range(0, 1)), '0);
            end
            window_settings++;
            if (s + l > DEPTH)
            begin
                repeat (8) offer_sample(SBITS'($urandom));
            end
            else
            begin
                span = s + l + $urandom_range(80, 160);
                while (span > 0)
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            seg_len = s + l + 2;
                            amp = 0;
                        end
                        1, 2:
                        begin
                            seg_len = $urandom_range(5, 20);
                            amp = SBITS;
                        end
                        3, 4, 5:
                        begin
                            seg_len = $urandom_range(3, 20);
                            amp = $urandom_range(16, 23);
                        end
                        default:
                        begin
                            seg_len = $urandom_range(10, 60);
                            amp = $urandom_range(0, 8);
                        end
                    endcase
                    while (seg_len > 0 && span > 0)
                    begin
                        value = noise_sample(amp);
                        if (amp != 0 && $urandom_range(0, 49) == 0)
                        begin
                            value = {$urandom_range(0, 1) == 1, {(SBITS-1){1'b0}}};
                        end
                        offer_sample(value);
                        random_items++;
                        seg_len--;
                        span--;
                    end
                end
            end
            wait_for_results();
        end
    endtask

    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (idle_enabled && stall_left == 0 && $urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(1, 9);
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    result_ch.ready <= 1'b0;
                end
                else
                begin
                    result_ch.ready <= rst_n;
                end
            end
        end
    end

    always @(posedge clk)
    begin : ratio_check
        ratio_result_t want;
        ratio_result_t got;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.ratio = result_ch.ratio;
            got.warmed = result_ch.warmed;
            got.config_bad = result_ch.config_bad;
            if (expected_ratios.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result %0d: ratio %h warmed %b config_bad %b",
                             results_seen, got.ratio, got.warmed, got.config_bad);
                end
            end
            else
            begin
                want = expected_ratios.pop_front();
                if (got.ratio !== want.ratio || got.warmed !== want.warmed ||
                    got.config_bad !== want.config_bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Result %0d: expected ratio %h warmed %b config_bad %b, %s",
                                 results_seen, want.ratio, want.warmed, want.config_bad,
                                 $sformatf("got ratio %h warmed %b config_bad %b",
                                           got.ratio, got.warmed, got.config_bad));
                    end
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) || cfg_we)
        begin
            quiet_cycles = 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles.", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles++;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_STA;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        sta_len = STA_RESET;
        lta_len = LTA_RESET;
        clear_windows();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_lengths();
        test_edge_cases();
        test_oversized_windows();
        test_full_store_windows();
        test_backpressure();
        test_random_windows();
        $display("Run covered %0d samples (%0d random) over %0d window settings, %0d length writes.",
                 samples_sent, random_items, window_settings, length_writes);
        $display("Ratios computed %0d, saturated %0d, zero long sums %0d, oversized %0d, errors %0d.",
                 computed_count, saturated_count, zero_long_count, oversized_count, mismatches);
        if (mismatches == 0 && expected_ratios.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sta_lta_ratio_detector.f
+incdir+hw/rtl
hw/rtl/stalta_pkg.sv
hw/rtl/stalta_if.sv
hw/rtl/sta_lta_ratio_detector.sv
test/testbench.sv
